// ----- src/ordered_list_insert_delete_core_assert.svh -----
// Assertion macros shared by the ordered list checker.
`ifndef ORDERED_LIST_INSERT_DELETE_CORE_ASSERT_SVH
`define ORDERED_LIST_INSERT_DELETE_CORE_ASSERT_SVH

// Clocked assertion, off while reset is held.
`define OLID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Implication whose consequent must hold in the cycle after the antecedent.
`define OLID_ASSERT_NEXT(lbl, ante, cons, msg) \
  `OLID_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ----- src/olid_pkg.sv -----
// Shared types and codes for the ordered list core.
package olid_pkg;

  // Request command codes
  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_DELETE = 3'd1;
  localparam logic [2:0] CMD_GET    = 3'd2;
  localparam logic [2:0] CMD_LOCATE = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_WALK,
    S_INS_PUT,
    S_DEL_WALK,
    S_GET_READ,
    S_LOC_WALK,
    S_FINISH
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       latch;
    logic       setup_ins;
    logic       setup_del;
    logic       setup_get;
    logic       setup_loc;
    logic       do_clear;
    logic       set_status;
    logic [1:0] status_code;
    logic       walk;
    logic       walk_down;
    logic       walk_write;
    logic       put_new;
    logic       dec_count;
    logic       take_read;
    logic       take_match;
    logic       load_out;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] cmd;
    logic       ins_ok;
    logic       full;
    logic       pos_ok;
    logic       walk_done;
    logic       match;
    logic       out_busy;
  } dp_stat_t;

endpackage

// ----- src/olid_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module olid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/olid_datapath.sv -----
// Datapath: request registers, element store, walk counters and result register.
module olid_datapath #(
  parameter int CAPACITY = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [2:0]          in_cmd,
  input  logic [7:0]          in_position,
  input  logic [7:0]          in_value,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [7:0]          out_read_value,
  output logic [7:0]          out_found_position,
  output logic [7:0]          out_list_length_out,
  output logic                out_is_empty,
  input  olid_pkg::ctrl_cmd_t ctrl,
  output olid_pkg::dp_stat_t  stat
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > 8) ? CW : 8) + 1;

  logic [2:0]    cmd_r;
  logic [7:0]    pos_r;
  logic [7:0]    val_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] last_r, last_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [7:0]    rd_val_r, rd_val_nxt;
  logic [CW-1:0] found_r, found_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r;
  logic [7:0]    out_read_r;
  logic [7:0]    out_found_r;
  logic [7:0]    out_len_r;
  logic          out_empty_r;

  logic [PW-1:0] pos_w, cnt_w;
  logic [AW-1:0] pos_addr;
  logic [AW-1:0] walk_waddr;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // Position checks against the current length
  assign pos_w    = PW'(pos_r);
  assign cnt_w    = PW'(count_r);
  assign pos_addr = AW'(pos_w - PW'(1));

  assign stat.cmd       = cmd_r;
  assign stat.ins_ok    = (pos_r != 8'd0) && (pos_w <= cnt_w + PW'(1));
  assign stat.full      = (count_r == CW'(CAPACITY));
  assign stat.pos_ok    = (pos_r != 8'd0) && (pos_w <= cnt_w);
  assign stat.walk_done = (rem_r == '0) && !pend_r;
  assign stat.match     = pend_r && (ram_rdata == val_r);
  assign stat.out_busy  = out_valid_r && !out_ready;

  // Store port steering: a walk moves the previous read one slot over
  assign walk_waddr = ctrl.walk_down ? (last_r + AW'(1)) : (last_r - AW'(1));
  assign ram_we     = (ctrl.walk && ctrl.walk_write && pend_r) || ctrl.put_new;
  assign ram_waddr  = ctrl.put_new ? pos_addr : walk_waddr;
  assign ram_wdata  = ctrl.put_new ? val_r : ram_rdata;
  assign ram_raddr  = ctrl.setup_get ? pos_addr : idx_r;

  olid_ram #(
    .WIDTH(8),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  // Next values of the walk and result state
  always_comb begin
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    rem_nxt    = rem_r;
    pend_nxt   = pend_r;
    last_nxt   = last_r;
    status_nxt = status_r;
    rd_val_nxt = rd_val_r;
    found_nxt  = found_r;

    if (ctrl.latch) begin
      status_nxt = olid_pkg::ST_OK;
      rd_val_nxt = 8'd0;
      found_nxt  = '0;
    end
    if (ctrl.set_status) begin
      status_nxt = ctrl.status_code;
    end
    if (ctrl.setup_ins) begin
      idx_nxt  = AW'(count_r - CW'(1));
      rem_nxt  = CW'(cnt_w - pos_w + PW'(1));
      pend_nxt = 1'b0;
    end
    if (ctrl.setup_del) begin
      idx_nxt  = AW'(pos_w);
      rem_nxt  = CW'(cnt_w - pos_w);
      pend_nxt = 1'b0;
    end
    if (ctrl.setup_loc) begin
      idx_nxt  = '0;
      rem_nxt  = count_r;
      pend_nxt = 1'b0;
    end
    // Advance the walk one entry
    if (ctrl.walk) begin
      if (rem_r != '0) begin
        idx_nxt  = ctrl.walk_down ? (idx_r - AW'(1)) : (idx_r + AW'(1));
        rem_nxt  = rem_r - CW'(1);
        pend_nxt = 1'b1;
        last_nxt = idx_r;
      end else begin
        pend_nxt = 1'b0;
      end
    end
    if (ctrl.put_new) begin
      count_nxt = count_r + CW'(1);
    end
    if (ctrl.dec_count) begin
      count_nxt = count_r - CW'(1);
    end
    if (ctrl.do_clear) begin
      count_nxt = '0;
    end
    if (ctrl.take_read) begin
      rd_val_nxt = ram_rdata;
    end
    if (ctrl.take_match) begin
      found_nxt = CW'(last_r) + CW'(1);
    end
  end

  // Hold the result until the consumer takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      cmd_r <= in_cmd;
      pos_r <= in_position;
      val_r <= in_value;
    end
    idx_r    <= idx_nxt;
    rem_r    <= rem_nxt;
    last_r   <= last_nxt;
    status_r <= status_nxt;
    rd_val_r <= rd_val_nxt;
    found_r  <= found_nxt;
    if (ctrl.load_out) begin
      out_status_r <= status_r;
      out_read_r   <= rd_val_r;
      out_found_r  <= 8'(found_r);
      out_len_r    <= 8'(count_r);
      out_empty_r  <= (count_r == '0);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_read_value      = out_read_r;
  assign out_found_position  = out_found_r;
  assign out_list_length_out = out_len_r;
  assign out_is_empty        = out_empty_r;

endmodule

// ----- src/olid_ctrl.sv -----
// Controller: sequences each request through decode, store walk and result load.
module olid_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  olid_pkg::dp_stat_t  stat,
  output olid_pkg::ctrl_cmd_t ctrl
);

  olid_pkg::state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      olid_pkg::S_IDLE: begin
        if (in_valid) state_nxt = olid_pkg::S_DECODE;
      end
      olid_pkg::S_DECODE: begin
        case (stat.cmd)
          olid_pkg::CMD_INSERT: begin
            if (!stat.ins_ok || stat.full) state_nxt = olid_pkg::S_FINISH;
            else state_nxt = olid_pkg::S_INS_WALK;
          end
          olid_pkg::CMD_DELETE: begin
            state_nxt = stat.pos_ok ? olid_pkg::S_DEL_WALK : olid_pkg::S_FINISH;
          end
          olid_pkg::CMD_GET: begin
            state_nxt = stat.pos_ok ? olid_pkg::S_GET_READ : olid_pkg::S_FINISH;
          end
          olid_pkg::CMD_LOCATE: state_nxt = olid_pkg::S_LOC_WALK;
          default:              state_nxt = olid_pkg::S_FINISH;
        endcase
      end
      olid_pkg::S_INS_WALK: begin
        if (stat.walk_done) state_nxt = olid_pkg::S_INS_PUT;
      end
      olid_pkg::S_INS_PUT:  state_nxt = olid_pkg::S_FINISH;
      olid_pkg::S_DEL_WALK: begin
        if (stat.walk_done) state_nxt = olid_pkg::S_FINISH;
      end
      olid_pkg::S_GET_READ: state_nxt = olid_pkg::S_FINISH;
      olid_pkg::S_LOC_WALK: begin
        if (stat.match || stat.walk_done) state_nxt = olid_pkg::S_FINISH;
      end
      olid_pkg::S_FINISH: begin
        if (!stat.out_busy) state_nxt = olid_pkg::S_IDLE;
      end
      default: state_nxt = olid_pkg::S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    ctrl     = '0;
    in_ready = 1'b0;
    case (state_r)
      olid_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        ctrl.latch = in_valid;
      end
      olid_pkg::S_DECODE: begin
        case (stat.cmd)
          olid_pkg::CMD_INSERT: begin
            if (!stat.ins_ok) begin
              ctrl.set_status  = 1'b1;
              ctrl.status_code = olid_pkg::ST_BADPOS;
            end else if (stat.full) begin
              ctrl.set_status  = 1'b1;
              ctrl.status_code = olid_pkg::ST_FULL;
            end else begin
              ctrl.setup_ins = 1'b1;
            end
          end
          olid_pkg::CMD_DELETE: begin
            if (stat.pos_ok) begin
              ctrl.setup_del = 1'b1;
            end else begin
              ctrl.set_status  = 1'b1;
              ctrl.status_code = olid_pkg::ST_BADPOS;
            end
          end
          olid_pkg::CMD_GET: begin
            if (stat.pos_ok) begin
              ctrl.setup_get = 1'b1;
            end else begin
              ctrl.set_status  = 1'b1;
              ctrl.status_code = olid_pkg::ST_BADPOS;
            end
          end
          olid_pkg::CMD_LOCATE: ctrl.setup_loc = 1'b1;
          olid_pkg::CMD_CLEAR:  ctrl.do_clear  = 1'b1;
          default: ;
        endcase
      end
      olid_pkg::S_INS_WALK: begin
        ctrl.walk       = 1'b1;
        ctrl.walk_down  = 1'b1;
        ctrl.walk_write = 1'b1;
      end
      olid_pkg::S_INS_PUT: ctrl.put_new = 1'b1;
      olid_pkg::S_DEL_WALK: begin
        ctrl.walk       = 1'b1;
        ctrl.walk_write = 1'b1;
        ctrl.dec_count  = stat.walk_done;
      end
      olid_pkg::S_GET_READ: ctrl.take_read = 1'b1;
      olid_pkg::S_LOC_WALK: begin
        ctrl.walk       = 1'b1;
        ctrl.take_match = stat.match;
      end
      olid_pkg::S_FINISH: ctrl.load_out = !stat.out_busy;
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= olid_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/ordered_list_insert_delete_core.sv -----
// Ordered byte list: one request at a time, store walked one entry per cycle.
// Insert shifts the entries from the position onward up, then writes the new byte; delete
// shifts the later entries down; locate walks until a match or the end; get reads one entry.
// One request in flight: a new request is taken only after the last result is loaded.
// A finished result sits in an output register, so the next request is taken meanwhile.
// Reset: synchronous, active low; clears the length, stored entries stay undefined.
module ordered_list_insert_delete_core #(
  parameter int CAPACITY = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_cmd,
  input  logic [7:0] in_position,
  input  logic [7:0] in_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [7:0] out_read_value,
  output logic [7:0] out_found_position,
  output logic [7:0] out_list_length_out,
  output logic       out_is_empty
);

  olid_pkg::ctrl_cmd_t ctrl;
  olid_pkg::dp_stat_t  stat;

  olid_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .ctrl    (ctrl)
  );

  olid_datapath #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_cmd             (in_cmd),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_read_value     (out_read_value),
    .out_found_position (out_found_position),
    .out_list_length_out(out_list_length_out),
    .out_is_empty       (out_is_empty),
    .ctrl               (ctrl),
    .stat               (stat)
  );

endmodule

// ----- src/olid_checker.sv -----
// Port-level checker for the ordered list core, bound to the top level.
`include "ordered_list_insert_delete_core_assert.svh"

module olid_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic [7:0] out_read_value,
  input logic [7:0] out_found_position,
  input logic [7:0] out_list_length_out,
  input logic       out_is_empty
);

  // A stalled result holds valid and payload
  `OLID_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_read_value) && $stable(out_found_position) && $stable(out_list_length_out), "stalled result changed")

  // One request in flight: ready drops after an accept
  `OLID_ASSERT_NEXT(a_one_request, in_valid && in_ready, !in_ready, "request accepted while busy")

  // A rejected request returns no data
  `OLID_ASSERT(a_reject_zero, (out_valid && out_status != olid_pkg::ST_OK) |-> (out_read_value == 8'd0 && out_found_position == 8'd0), "rejected request carries data")

  // A nonzero length is never reported as empty
  `OLID_ASSERT(a_len_empty, (out_valid && out_list_length_out != 8'd0) |-> !out_is_empty, "empty flag disagrees with length")

endmodule

bind ordered_list_insert_delete_core olid_checker u_olid_checker (.*);

// ----- test/list_result_checker.sv -----
// Request/result checker for the ordered list core: predicts each result and compares it.
module list_result_checker #(
  parameter int CAPACITY = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [2:0] in_cmd,
  input  logic [7:0] in_position,
  input  logic [7:0] in_value,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] out_status,
  input  logic [7:0] out_read_value,
  input  logic [7:0] out_found_position,
  input  logic [7:0] out_list_length_out,
  input  logic       out_is_empty,
  output int         pending_results,
  output int         mismatches,
  output int         results_seen,
  output int         full_rejects,
  output int         locate_hits
);

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] read_value;
    logic [7:0] found_pos;
    logic [7:0] length;
    logic       empty;
  } list_result_t;

  // Shadow copy of the list contents and length
  logic [7:0]   shadow_elems [CAPACITY];
  int           shadow_count;
  list_result_t expected_results [$];

  int err_total;
  int seen_total;
  int full_total;
  int hit_total;

  // Apply one request to the shadow list and return the result it must produce
  function automatic list_result_t predict_list_op(input logic [2:0] cmd,
                                                   input logic [7:0] pos,
                                                   input logic [7:0] val);
    list_result_t res;
    int           k;
    int           p;
    res        = '0;
    res.status = olid_pkg::ST_OK;
    p          = int'(pos);
    case (cmd)
      olid_pkg::CMD_INSERT: begin
        if (p < 1 || p > shadow_count + 1) begin
          res.status = olid_pkg::ST_BADPOS;
        end else if (shadow_count >= CAPACITY) begin
          res.status = olid_pkg::ST_FULL;
        end else begin
          // shift the tail up by one, then drop the new byte in place
          for (k = shadow_count; k >= p; k--) shadow_elems[k] = shadow_elems[k-1];
          shadow_elems[p-1] = val;
          shadow_count++;
        end
      end
      olid_pkg::CMD_DELETE: begin
        if (p < 1 || p > shadow_count) begin
          res.status = olid_pkg::ST_BADPOS;
        end else begin
          for (k = p - 1; k + 1 < shadow_count; k++) shadow_elems[k] = shadow_elems[k+1];
          shadow_count--;
        end
      end
      olid_pkg::CMD_GET: begin
        if (p < 1 || p > shadow_count) res.status = olid_pkg::ST_BADPOS;
        else res.read_value = shadow_elems[p-1];
      end
      olid_pkg::CMD_LOCATE: begin
        // keep the first match only
        for (k = 0; k < shadow_count; k++) begin
          if (res.found_pos == 8'd0 && shadow_elems[k] == val) res.found_pos = 8'(k + 1);
        end
      end
      olid_pkg::CMD_CLEAR: begin
        shadow_count = 0;
      end
      default: ;
    endcase
    res.length = shadow_count[7:0];
    res.empty  = (shadow_count == 0);
    return res;
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] exp_val,
                                        input logic [7:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      err_total++;
    end
  endfunction

  // Watch both channels: retire the oldest expectation, then queue the new request
  always @(posedge clk) begin : watch_channels
    list_result_t exp_res;
    if (!rst_n) begin
      shadow_count = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        seen_total++;
        if (expected_results.size() == 0) begin
          $error("result arrived with no request outstanding");
          err_total++;
        end else begin
          exp_res = expected_results.pop_front();
          compare_field("status", 8'(exp_res.status), 8'(out_status));
          compare_field("read_value", exp_res.read_value, out_read_value);
          compare_field("found_position", exp_res.found_pos, out_found_position);
          compare_field("list_length_out", exp_res.length, out_list_length_out);
          compare_field("is_empty", 8'(exp_res.empty), 8'(out_is_empty));
        end
      end
      if (in_valid && in_ready) begin
        exp_res = predict_list_op(in_cmd, in_position, in_value);
        if (exp_res.status == olid_pkg::ST_FULL) full_total++;
        if (exp_res.found_pos != 8'd0) hit_total++;
        expected_results.push_back(exp_res);
      end
    end
    pending_results <= expected_results.size();
    mismatches      <= err_total;
    results_seen    <= seen_total;
    full_rejects    <= full_total;
    locate_hits     <= hit_total;
  end

endmodule

// ----- test/tb_top.sv -----
// Testbench top for the ordered list core: clock, reset, request stimulus and verdict.
module tb_top;

  localparam int LIST_CAP         = 128;
  localparam int HALF_PERIOD      = 6;
  localparam int RUN_LIMIT_CYCLES = 2_000_000;
  localparam int RANDOM_PER_PHASE = 250;

  // Command codes the core ignores
  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_MID   = 3'd6;
  localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

  // Random mix selectors
  localparam int MIX_GROW   = 0;
  localparam int MIX_SPREAD = 1;
  localparam int MIX_SHRINK = 2;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [2:0] in_cmd      = olid_pkg::CMD_CLEAR;
  logic [7:0] in_position = 8'd0;
  logic [7:0] in_value    = 8'd0;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  logic [1:0] out_status;
  logic [7:0] out_read_value;
  logic [7:0] out_found_position;
  logic [7:0] out_list_length_out;
  logic       out_is_empty;

  int pending_results;
  int mismatches;
  int results_seen;
  int full_rejects;
  int locate_hits;

  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int list_len_est = 0;
  int items_sent   = 0;

  always #HALF_PERIOD clk = ~clk;

  ordered_list_insert_delete_core #(
    .CAPACITY(LIST_CAP)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_read_value     (out_read_value),
    .out_found_position (out_found_position),
    .out_list_length_out(out_list_length_out),
    .out_is_empty       (out_is_empty)
  );

  list_result_checker #(
    .CAPACITY(LIST_CAP)
  ) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_read_value     (out_read_value),
    .out_found_position (out_found_position),
    .out_list_length_out(out_list_length_out),
    .out_is_empty       (out_is_empty),
    .pending_results    (pending_results),
    .mismatches         (mismatches),
    .results_seen       (results_seen),
    .full_rejects       (full_rejects),
    .locate_hits        (locate_hits)
  );

  // Stall the result channel at the current rate
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Present one request, hold it until taken, and keep a rough length for aiming positions
  task automatic send_request(input logic [2:0] cmd, input int pos, input int val);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_position <= pos[7:0];
    in_value    <= val[7:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (cmd)
      olid_pkg::CMD_INSERT: begin
        if (pos >= 1 && pos <= list_len_est + 1 && list_len_est < LIST_CAP) list_len_est++;
      end
      olid_pkg::CMD_DELETE: begin
        if (pos >= 1 && pos <= list_len_est) list_len_est--;
      end
      olid_pkg::CMD_CLEAR: list_len_est = 0;
      default: ;
    endcase
    items_sent++;
  endtask

  // Mostly in range, with edges and wild values mixed in
  function automatic int pick_position(input logic [2:0] cmd);
    int r;
    int top_pos;
    r       = $urandom_range(99);
    top_pos = (cmd == olid_pkg::CMD_INSERT) ? list_len_est + 1 : list_len_est;
    if (r < 78 && top_pos >= 1) return $urandom_range(top_pos, 1);
    else if (r < 86) return 0;
    else if (r < 93) return top_pos + 1;
    else return $urandom_range(255, 0);
  endfunction

  // Small values half the time so that locate finds matches
  function automatic int pick_value();
    if ($urandom_range(1) == 1) return $urandom_range(15, 0);
    else return $urandom_range(255, 0);
  endfunction

  task automatic random_request(input int mix);
    int         r;
    int         ins_w;
    int         del_w;
    logic [2:0] cmd;
    r = $urandom_range(99);
    case (mix)
      MIX_GROW:   ins_w = 52;
      MIX_SPREAD: ins_w = 34;
      MIX_SHRINK: ins_w = 15;
      default:    ins_w = 34;
    endcase
    del_w = 67 - ins_w;
    if (r < ins_w) cmd = olid_pkg::CMD_INSERT;
    else if (r < ins_w + del_w) cmd = olid_pkg::CMD_DELETE;
    else if (r < ins_w + del_w + 15) cmd = olid_pkg::CMD_GET;
    else if (r < ins_w + del_w + 30) cmd = olid_pkg::CMD_LOCATE;
    else if (r < ins_w + del_w + 31) cmd = olid_pkg::CMD_CLEAR;
    else cmd = 3'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
    send_request(cmd, pick_position(cmd), pick_value());
  endtask

  // Fill to capacity, then probe the full list and its top end
  task automatic fill_and_probe();
    while (list_len_est < LIST_CAP) begin
      send_request(olid_pkg::CMD_INSERT, $urandom_range(list_len_est + 1, 1), pick_value());
    end
    send_request(olid_pkg::CMD_INSERT, $urandom_range(LIST_CAP + 1, 1), pick_value());
    send_request(olid_pkg::CMD_INSERT, LIST_CAP + 2, pick_value());
    send_request(olid_pkg::CMD_INSERT, 0, pick_value());
    send_request(olid_pkg::CMD_GET, LIST_CAP, 0);
    send_request(olid_pkg::CMD_GET, LIST_CAP + 1, 0);
    send_request(olid_pkg::CMD_LOCATE, 0, pick_value());
    send_request(olid_pkg::CMD_DELETE, LIST_CAP, 0);
    send_request(olid_pkg::CMD_DELETE, 1, 0);
    send_request(olid_pkg::CMD_INSERT, list_len_est + 1, pick_value());
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct);
    int i;
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    fill_and_probe();
    for (i = 0; i < RANDOM_PER_PHASE; i++) random_request((i / 40) % 3);
  endtask

  // Stimulus and verdict
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 30;
    rx_idle_pct <= 70;

    // empty list corners
    send_request(olid_pkg::CMD_CLEAR, 0, 0);
    send_request(olid_pkg::CMD_GET, 0, 0);
    send_request(olid_pkg::CMD_GET, 1, 0);
    send_request(olid_pkg::CMD_DELETE, 1, 0);
    send_request(olid_pkg::CMD_LOCATE, 0, 0);
    send_request(olid_pkg::CMD_INSERT, 0, 8'h11);
    send_request(olid_pkg::CMD_INSERT, 2, 8'h22);
    // build FF 55 00 80 through front, end and middle inserts
    send_request(olid_pkg::CMD_INSERT, 1, 8'h00);
    send_request(olid_pkg::CMD_INSERT, 1, 8'hFF);
    send_request(olid_pkg::CMD_INSERT, 3, 8'h80);
    send_request(olid_pkg::CMD_INSERT, 2, 8'h55);
    send_request(olid_pkg::CMD_GET, 1, 0);
    send_request(olid_pkg::CMD_GET, 4, 0);
    send_request(olid_pkg::CMD_GET, 5, 0);
    send_request(olid_pkg::CMD_LOCATE, 0, 8'hFF);
    send_request(olid_pkg::CMD_LOCATE, 0, 8'h80);
    send_request(olid_pkg::CMD_LOCATE, 0, 8'h7F);
    send_request(olid_pkg::CMD_DELETE, 2, 0);
    send_request(olid_pkg::CMD_DELETE, 3, 0);
    send_request(olid_pkg::CMD_DELETE, 0, 0);
    send_request(CMD_UNUSED_FIRST, 8'hFF, 8'hFF);
    send_request(CMD_UNUSED_MID, 1, 8'h01);
    send_request(CMD_UNUSED_LAST, 0, 0);
    send_request(olid_pkg::CMD_INSERT, 8'hFF, 8'hAA);
    send_request(olid_pkg::CMD_CLEAR, 8'hFF, 8'hFF);
    send_request(olid_pkg::CMD_GET, 1, 0);

    run_phase(30, 70);
    run_phase(70, 30);
    run_phase(0, 0);

    // drain the remaining results
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d requests over three idle mixes, %0d results checked",
             items_sent, results_seen);
    $display("full-list rejects seen: %0d, locate hits seen: %0d", full_rejects, locate_hits);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(RUN_LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("simulation failed");
    $finish;
  end

endmodule
